// File: design/pcd_pkg.sv
// Shared types and constants for the pinned cache directory.
package pcd_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int ID_BITS_DEF = 32;
    localparam int PIN_BITS    = 8;
    localparam logic [PIN_BITS-1:0] PIN_MAX = 8'hFF;

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_NEW     = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_VICTIM = 2'd1;
    localparam logic [1:0] ST_BAD_REL   = 2'd2;
    localparam logic [1:0] ST_PIN_SAT   = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] node_id;
        logic        is_index;
        logic [5:0]  slot;
        logic        modified;
    } req_t;

    typedef struct packed {
        logic [5:0]  slot_out;
        logic        hit;
        logic        load_needed;
        logic        evicted;
        logic [31:0] evicted_id;
        logic [1:0]  status;
    } rsp_t;

endpackage

// File: design/pinned_cache_directory_class_eviction.sv
// Pinned cache directory: slot records in one memory, walked by a sequencer.
//
// Usage: drive req and raise start while busy is low; the beat is taken at
// that clock edge and busy rises until the command is finished. Exactly one
// result beat follows each command: rsp is valid while done is high, for one
// cycle only, and the receiver must take it then.
// A get or new walks the slot memory twice: a scan pass finds a hit (get
// only), the lowest free slot and the best victim of each class; an update
// pass renumbers class and lookup ranks when a slot is filled. A get that
// hits skips the update pass. A release reads its slot once and walks the
// memory only when it moves a clean slot to its dirty class. The slot
// memory has a single read port, and a walk reads one entry per cycle.
// Unknown commands return an all-zero result.
// Reset empties the directory at once through per-slot used flags; the slot
// memory itself needs no clearing pass.
module pinned_cache_directory_class_eviction #(
    parameter int SLOTS   = pcd_pkg::SLOTS_DEF,
    parameter int ID_BITS = pcd_pkg::ID_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pcd_pkg::req_t req,
    output logic          done,
    output pcd_pkg::rsp_t rsp
);
    import pcd_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_REL  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic                dirty;
        logic                kind;
        logic [PIN_BITS-1:0] pin;
        logic [SW-1:0]       cr;
        logic [SW-1:0]       lr;
    } ent_t;

    // Slot memory
    ent_t            mem [SLOTS];
    ent_t            rdata;
    logic [SW-1:0]   raddr;
    logic            we;
    logic [SW-1:0]   waddr;
    ent_t            wdata;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    req_t               req_reg, req_next;
    logic [SLOTS-1:0]   used_reg, used_next;
    rsp_t               rsp_reg, rsp_next;
    logic               done_reg, done_next;

    logic               fv_reg, fv_next;
    logic [SW-1:0]      fs_reg, fs_next;
    ent_t               fe_reg, fe_next;
    logic               freev_reg, freev_next;
    logic [SW-1:0]      free_reg, free_next;
    logic [3:0]         vv_reg, vv_next;
    logic [SW-1:0]      vs_reg [4], vs_next [4];
    ent_t               ve_reg [4], ve_next [4];

    logic [SW-1:0]      tgt_reg, tgt_next;
    ent_t               tent_reg, tent_next;
    logic               wtgt_reg, wtgt_next;
    logic               setu_reg, setu_next;
    logic               rm_reg, rm_next;
    logic               rmlk_reg, rmlk_next;
    logic [1:0]         rmc_reg, rmc_next;
    logic [SW-1:0]      rmcr_reg, rmcr_next;
    logic [SW-1:0]      rmlr_reg, rmlr_next;
    logic               ins_reg, ins_next;
    logic               inslk_reg, inslk_next;
    logic [1:0]         insc_reg, insc_next;

    logic [SW-1:0]      pidx;
    logic [1:0]         ecls;
    ent_t               upd_e;
    logic               rs_ok;
    logic [SW-1:0]      rs_idx;
    logic [ID_BITS-1:0] id_in;

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign rsp   = rsp_reg;
    assign pidx  = SW'(cnt_reg - CW'(1));
    assign ecls  = {rdata.dirty, rdata.kind};
    assign id_in = ID_BITS'(req_reg.node_id);
    assign rs_ok = ({1'b0, req_reg.slot} < 7'(SLOTS));
    assign rs_idx = SW'(req_reg.slot);

    // Read the memory and take one write per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    // Pick the read address: slot to release at the accept, else the walk index
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            raddr = SW'(req.slot);
        end
        else
        begin
            raddr = SW'(cnt_reg);
        end
    end

    // Renumber ranks of one walked entry
    always_comb
    begin
        upd_e = rdata;
        if (rm_reg && ecls == rmc_reg && rdata.cr > rmcr_reg)
        begin
            upd_e.cr = upd_e.cr - SW'(1);
        end
        if (rmlk_reg && rdata.lr > rmlr_reg)
        begin
            upd_e.lr = upd_e.lr - SW'(1);
        end
        if (ins_reg && ecls == insc_reg)
        begin
            upd_e.cr = upd_e.cr + SW'(1);
        end
        if (inslk_reg)
        begin
            upd_e.lr = upd_e.lr + SW'(1);
        end
    end

    // Sequence the command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        used_next  = used_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        fv_next    = fv_reg;
        fs_next    = fs_reg;
        fe_next    = fe_reg;
        freev_next = freev_reg;
        free_next  = free_reg;
        vv_next    = vv_reg;
        for (int c = 0; c < 4; c++)
        begin
            vs_next[c] = vs_reg[c];
            ve_next[c] = ve_reg[c];
        end
        tgt_next   = tgt_reg;
        tent_next  = tent_reg;
        wtgt_next  = wtgt_reg;
        setu_next  = setu_reg;
        rm_next    = rm_reg;
        rmlk_next  = rmlk_reg;
        rmc_next   = rmc_reg;
        rmcr_next  = rmcr_reg;
        rmlr_next  = rmlr_reg;
        ins_next   = ins_reg;
        inslk_next = inslk_reg;
        insc_next  = insc_reg;
        we         = 1'b0;
        waddr      = tgt_reg;
        wdata      = tent_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    rsp_next   = '0;
                    cnt_next   = '0;
                    fv_next    = 1'b0;
                    freev_next = 1'b0;
                    vv_next    = '0;
                    wtgt_next  = 1'b0;
                    setu_next  = 1'b0;
                    rm_next    = 1'b0;
                    rmlk_next  = 1'b0;
                    ins_next   = 1'b0;
                    inslk_next = 1'b0;
                    if (req.cmd == CMD_GET || req.cmd == CMD_NEW)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req.cmd == CMD_RELEASE)
                    begin
                        state_next = S_REL;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_SCAN:
            begin
                // Track hit, lowest free slot and per-class victim
                if (cnt_reg != '0)
                begin
                    if (used_reg[pidx])
                    begin
                        if (req_reg.cmd == CMD_GET && rdata.id == id_in &&
                            (!fv_reg || rdata.lr < fe_reg.lr))
                        begin
                            fv_next = 1'b1;
                            fs_next = pidx;
                            fe_next = rdata;
                        end
                        if (rdata.pin == '0 &&
                            (!vv_reg[ecls] || rdata.cr < ve_reg[ecls].cr))
                        begin
                            vv_next[ecls] = 1'b1;
                            vs_next[ecls] = pidx;
                            ve_next[ecls] = rdata;
                        end
                    end
                    else if (!freev_reg)
                    begin
                        freev_next = 1'b1;
                        free_next  = pidx;
                    end
                end
                if (cnt_reg == CW'(SLOTS))
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            S_DEC:
            begin
                cnt_next   = '0;
                state_next = S_FIN;
                if (fv_reg)
                begin
                    rsp_next.slot_out = 6'(fs_reg);
                    rsp_next.hit      = 1'b1;
                    if (fe_reg.pin == PIN_MAX)
                    begin
                        rsp_next.status = ST_PIN_SAT;
                    end
                    else
                    begin
                        tgt_next      = fs_reg;
                        tent_next     = fe_reg;
                        tent_next.pin = fe_reg.pin + PIN_BITS'(1);
                        wtgt_next     = 1'b1;
                    end
                end
                else if (freev_reg || vv_reg != '0)
                begin
                    if (freev_reg)
                    begin
                        tgt_next = free_reg;
                    end
                    else
                    begin
                        for (int c = 3; c >= 0; c--)
                        begin
                            if (vv_reg[c])
                            begin
                                tgt_next = vs_reg[c];
                                rmc_next = 2'(c);
                                rmcr_next = ve_reg[c].cr;
                                rmlr_next = ve_reg[c].lr;
                                rsp_next.evicted_id = 32'(ve_reg[c].id);
                            end
                        end
                        rsp_next.evicted = 1'b1;
                        rm_next   = 1'b1;
                        rmlk_next = 1'b1;
                    end
                    tent_next.id    = id_in;
                    tent_next.dirty = (req_reg.cmd == CMD_NEW);
                    tent_next.kind  = req_reg.is_index;
                    tent_next.pin   = PIN_BITS'(1);
                    tent_next.cr    = '0;
                    tent_next.lr    = '0;
                    insc_next  = {req_reg.cmd == CMD_NEW, req_reg.is_index};
                    ins_next   = 1'b1;
                    inslk_next = 1'b1;
                    wtgt_next  = 1'b1;
                    setu_next  = 1'b1;
                    rsp_next.slot_out    = 6'(tgt_next);
                    rsp_next.load_needed = (req_reg.cmd == CMD_GET);
                    state_next = S_UPD;
                end
                else
                begin
                    rsp_next.status = ST_NO_VICTIM;
                end
            end

            S_REL:
            begin
                // Check the slot and decide whether it changes class
                cnt_next          = '0;
                state_next        = S_FIN;
                rsp_next.slot_out = req_reg.slot;
                if (!rs_ok || !used_reg[rs_idx] || rdata.pin == '0)
                begin
                    rsp_next.status = ST_BAD_REL;
                end
                else
                begin
                    tgt_next      = rs_idx;
                    tent_next     = rdata;
                    tent_next.pin = rdata.pin - PIN_BITS'(1);
                    wtgt_next     = 1'b1;
                    if (req_reg.modified && !rdata.dirty)
                    begin
                        tent_next.dirty = 1'b1;
                        tent_next.cr    = '0;
                        rm_next    = 1'b1;
                        rmc_next   = {1'b0, rdata.kind};
                        rmcr_next  = rdata.cr;
                        ins_next   = 1'b1;
                        insc_next  = {1'b1, rdata.kind};
                        state_next = S_UPD;
                    end
                end
            end

            S_UPD:
            begin
                // Write back renumbered ranks, one entry behind the read
                if (cnt_reg != '0 && pidx != tgt_reg && used_reg[pidx])
                begin
                    we    = 1'b1;
                    waddr = pidx;
                    wdata = upd_e;
                end
                if (cnt_reg == CW'(SLOTS))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            S_FIN:
            begin
                we        = wtgt_reg;
                done_next = 1'b1;
                if (setu_reg)
                begin
                    used_next[tgt_reg] = 1'b1;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Advance payload and tracker registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        fv_reg    <= fv_next;
        fs_reg    <= fs_next;
        fe_reg    <= fe_next;
        freev_reg <= freev_next;
        free_reg  <= free_next;
        vv_reg    <= vv_next;
        for (int c = 0; c < 4; c++)
        begin
            vs_reg[c] <= vs_next[c];
            ve_reg[c] <= ve_next[c];
        end
        tgt_reg   <= tgt_next;
        tent_reg  <= tent_next;
        wtgt_reg  <= wtgt_next;
        setu_reg  <= setu_next;
        rm_reg    <= rm_next;
        rmlk_reg  <= rmlk_next;
        rmc_reg   <= rmc_next;
        rmcr_reg  <= rmcr_next;
        rmlr_reg  <= rmlr_next;
        ins_reg   <= ins_next;
        inslk_reg <= inslk_next;
        insc_reg  <= insc_next;
    end

endmodule

// File: tb/tb_top.sv
// Testbench for the pinned cache directory: directed and random commands, scoreboard check.
module tb_top;
    import pcd_pkg::*;

    localparam int NSLOT = SLOTS_DEF;

    // Scoreboard: holds a directory model and the queue of predicted result beats.
    class dir_scoreboard;
        bit          used  [NSLOT];
        bit [31:0]   id    [NSLOT];
        bit          dirty [NSLOT];
        bit          kind  [NSLOT];
        bit [7:0]    pins  [NSLOT];
        int          crank [NSLOT];
        int          lrank [NSLOT];
        int          nused;
        rsp_t        pending[$];
        int          errors;

        function int cls(int s);
            return dirty[s] * 2 + kind[s];
        endfunction

        function void class_add(int s);
            for (int t = 0; t < NSLOT; t++)
                if (t != s && used[t] && cls(t) == cls(s)) crank[t]++;
            crank[s] = 0;
        endfunction

        function void class_drop(int s);
            for (int t = 0; t < NSLOT; t++)
                if (t != s && used[t] && cls(t) == cls(s) && crank[t] > crank[s])
                    crank[t]--;
        endfunction

        function void recent_drop(int s);
            for (int t = 0; t < NSLOT; t++)
                if (t != s && used[t] && lrank[t] > lrank[s]) lrank[t]--;
        endfunction

        function int take_slot(output bit ev, output bit [31:0] evid);
            int best;
            ev = 0;
            evid = '0;
            if (nused < NSLOT)
                for (int s = 0; s < NSLOT; s++)
                    if (!used[s]) begin
                        nused++;
                        return s;
                    end
            for (int c = 0; c < 4; c++) begin
                best = -1;
                for (int s = 0; s < NSLOT; s++)
                    if (used[s] && pins[s] == 0 && cls(s) == c &&
                        (best < 0 || crank[s] < crank[best])) best = s;
                if (best >= 0) begin
                    class_drop(best);
                    recent_drop(best);
                    used[best] = 0;
                    ev = 1;
                    evid = id[best];
                    return best;
                end
            end
            return -1;
        endfunction

        // Note an accepted command beat and predict its result.
        function void note_request(req_t r);
            rsp_t e;
            int found, a;
            bit ev;
            bit [31:0] evid;
            e = '0;
            if (r.cmd == CMD_GET || r.cmd == CMD_NEW) begin
                found = -1;
                if (r.cmd == CMD_GET)
                    for (int s = 0; s < NSLOT; s++)
                        if (used[s] && id[s] == r.node_id &&
                            (found < 0 || lrank[s] < lrank[found])) found = s;
                if (found >= 0) begin
                    e.slot_out = 6'(found);
                    e.hit = 1;
                    if (pins[found] == PIN_MAX) e.status = ST_PIN_SAT;
                    else pins[found]++;
                end else begin
                    a = take_slot(ev, evid);
                    if (a < 0) e.status = ST_NO_VICTIM;
                    else begin
                        used[a] = 1;
                        id[a] = r.node_id;
                        kind[a] = r.is_index;
                        dirty[a] = (r.cmd == CMD_NEW);
                        pins[a] = 1;
                        class_add(a);
                        for (int t = 0; t < NSLOT; t++)
                            if (t != a && used[t]) lrank[t]++;
                        lrank[a] = 0;
                        e.slot_out = 6'(a);
                        e.load_needed = (r.cmd == CMD_GET);
                        e.evicted = ev;
                        e.evicted_id = evid;
                    end
                end
            end else if (r.cmd == CMD_RELEASE) begin
                e.slot_out = r.slot;
                if (r.slot >= NSLOT || !used[r.slot] || pins[r.slot] == 0)
                    e.status = ST_BAD_REL;
                else begin
                    if (r.modified && !dirty[r.slot]) begin
                        class_drop(r.slot);
                        dirty[r.slot] = 1;
                        class_add(r.slot);
                    end
                    pins[r.slot]--;
                end
            end
            pending.push_back(e);
        endfunction

        // Compare one result beat with the oldest prediction.
        function void check_result(rsp_t got);
            rsp_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.slot_out !== e.slot_out) begin
                $error("slot_out exp %0d got %0d", e.slot_out, got.slot_out); errors++;
            end
            if (got.hit !== e.hit) begin
                $error("hit exp %0d got %0d", e.hit, got.hit); errors++;
            end
            if (got.load_needed !== e.load_needed) begin
                $error("load_needed exp %0d got %0d", e.load_needed, got.load_needed);
                errors++;
            end
            if (got.evicted !== e.evicted) begin
                $error("evicted exp %0d got %0d", e.evicted, got.evicted); errors++;
            end
            if (got.evicted_id !== e.evicted_id) begin
                $error("evicted_id exp %h got %h", e.evicted_id, got.evicted_id); errors++;
            end
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
        endfunction
    endclass

    logic  clk = 0;
    logic  rst_n = 0;
    logic  start = 0;
    logic  busy;
    logic  done;
    req_t  req = '0;
    rsp_t  rsp;

    dir_scoreboard board = new();
    bit [31:0] id_pool [8];

    pinned_cache_directory_class_eviction i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .rsp(rsp)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Check every result beat at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && done) board.check_result(rsp);
    end

    // Send one command beat; start stays high into the next beat when there is no gap.
    task automatic send_cmd(req_t r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        req   <= r;
        start <= 1;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_request(r);
    endtask

    function automatic req_t mk(bit [1:0] c, bit [31:0] nid, bit k, bit [5:0] s, bit ch);
        req_t r;
        r.cmd = c;
        r.node_id = nid;
        r.is_index = k;
        r.slot = s;
        r.modified = ch;
        return r;
    endfunction

    function automatic req_t rand_req();
        int p;
        bit [1:0] c;
        p = $urandom_range(0, 99);
        if (p < 40) c = CMD_GET;
        else if (p < 55) c = CMD_NEW;
        else if (p < 97) c = CMD_RELEASE;
        else c = 2'd3;
        return mk(c,
            ($urandom_range(0, 7) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)],
            1'($urandom_range(0, 1)),
            ($urandom_range(0, 15) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7)),
            1'($urandom_range(0, 1)));
    endfunction

    initial
    begin
        int wait_cycles;
        for (int i = 0; i < 8; i++) id_pool[i] = $urandom();
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: fill the pool, duplicates, all pinned, bad releases, unknown cmd.
        send_cmd(mk(CMD_GET, 32'h0, 0, 0, 0));
        send_cmd(mk(CMD_GET, 32'hFFFF_FFFF, 1, 0, 0));
        send_cmd(mk(CMD_GET, 32'h0, 0, 0, 0));
        send_cmd(mk(CMD_NEW, 32'h1234, 1, 0, 0));
        send_cmd(mk(CMD_NEW, 32'h1234, 0, 0, 0));
        send_cmd(mk(CMD_GET, 32'h1234, 0, 0, 0));
        for (int i = 0; i < 3; i++) send_cmd(mk(CMD_NEW, 32'h100 + i, i[0], 0, 0));
        send_cmd(mk(CMD_GET, 32'hBEEF, 0, 0, 0));
        send_cmd(mk(CMD_RELEASE, 0, 0, 63, 1));
        send_cmd(mk(CMD_RELEASE, 0, 0, 8, 0));
        send_cmd(mk(CMD_RELEASE, 0, 0, 2, 1));
        send_cmd(mk(CMD_RELEASE, 0, 0, 1, 0));
        send_cmd(mk(CMD_RELEASE, 0, 0, 1, 0));
        send_cmd(mk(CMD_RELEASE, 0, 0, 3, 1));
        send_cmd(mk(CMD_GET, 32'hBEEF, 1, 0, 0));
        send_cmd(mk(CMD_NEW, 32'hCAFE, 0, 0, 0));
        send_cmd(mk(2'd3, 32'hFFFF_FFFF, 1, 63, 1));

        // Pin saturation: hit one id until its count tops out.
        for (int i = 0; i < 256; i++) send_cmd(mk(CMD_GET, 32'h1234, 0, 0, 0));
        for (int i = 0; i < 256; i++) send_cmd(mk(CMD_RELEASE, 0, 0, 4, 0));

        // Random traffic over a small id pool so hits and evictions are frequent.
        for (int n = 0; n < 1370; n++) send_cmd(rand_req());
        start <= 0;

        // Drain outstanding results, then let the block settle.
        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("pinned_cache_directory_class_eviction verification clean");
        else
            $display("pinned_cache_directory_class_eviction verification failed");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #10000000;
        $display("pinned_cache_directory_class_eviction verification failed");
        $finish;
    end
endmodule
